// ===== sv/fbpb_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpb_pkg
// Types and constants shared by the boot sector parameter decoder.
// ----------------------------------------------------------------------------
package fbpb_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MAX_SECTOR_BYTES    = 3'd0;
    localparam logic [2:0] REG_MAX_CLUSTER_BYTES   = 3'd1;
    localparam logic [2:0] REG_MIN_FAT_COUNT       = 3'd2;
    localparam logic [2:0] REG_MAX_FAT_COUNT       = 3'd3;
    localparam logic [2:0] REG_FAT12_CLUSTER_LIMIT = 3'd4;
    localparam logic [2:0] REG_FAT16_CLUSTER_LIMIT = 3'd5;
    localparam logic [2:0] REG_SINGLE_FAT_SUPPORT  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SECTOR_SIZE = 3'd1;
    localparam logic [2:0] ST_BAD_CLUSTER = 3'd2;
    localparam logic [2:0] ST_BAD_FATS    = 3'd3;
    localparam logic [2:0] ST_FAT32       = 3'd4;

    localparam int ROOT_NUM_W = 22;
    localparam int ROOT_DIV_W = 16;
    localparam int CL_NUM_W   = 32;
    localparam int CL_DIV_W   = 8;

    typedef struct packed {
        logic [15:0] bytes_per_sector;
        logic [7:0]  sectors_per_cluster;
        logic [7:0]  fat_copies;
        logic [15:0] root_entries;
        logic [15:0] sectors_per_fat;
        logic [15:0] reserved_sectors;
        logic [15:0] total_sectors_short;
        logic [31:0] total_sectors_long;
        logic        is_floppy;
    } sector_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] cluster_bytes;
        logic [20:0] root_dir_sectors;
        logic [16:0] fat_start_sector;
        logic [21:0] data_start_sector;
        logic [15:0] cluster_count;
        logic        is_fat16;
        logic        single_fat;
    } result_t;

    // side data riding along the root directory divider
    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] clbytes;
        logic [16:0] fatrec;
        logic [15:0] fsiz;
        logic [31:0] total;
        logic [7:0]  spc;
        logic        one_fat;
    } root_pay_t;

    // side data riding along the cluster count divider
    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] clbytes;
        logic [20:0] rdlen;
        logic [16:0] fatrec;
        logic [21:0] datrec;
        logic        fsiz_zero;
        logic        one_fat;
    } cl_pay_t;

endpackage

// ===== sv/fbpb_sector_if.sv =====
// ----------------------------------------------------------------------------
// fbpb_sector_if
// Valid/ready channel carrying one decoded boot sector record.
// ----------------------------------------------------------------------------
interface fbpb_sector_if;
    logic              valid;
    logic              ready;
    fbpb_pkg::sector_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fbpb_result_if.sv =====
// ----------------------------------------------------------------------------
// fbpb_result_if
// Valid/ready channel carrying one decode result.
// ----------------------------------------------------------------------------
interface fbpb_result_if;
    logic              valid;
    logic              ready;
    fbpb_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fbpb_div_cell.sv =====
// ----------------------------------------------------------------------------
// fbpb_div_cell
// One restoring division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
module fbpb_div_cell #(
    parameter int NW = 22,
    parameter int DW = 16,
    parameter int PW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [DW+NW-1:0] in_acc,
    input  logic [DW-1:0]    in_div,
    input  logic [PW-1:0]    in_pay,
    output logic             out_valid,
    output logic [DW+NW-1:0] out_acc,
    output logic [DW-1:0]    out_div,
    output logic [PW-1:0]    out_pay
);

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic [DW+NW-1:0] acc_next;
    logic             valid_reg;
    logic [DW+NW-1:0] acc_reg;
    logic [DW-1:0]    div_reg;
    logic [PW-1:0]    pay_reg;

    // top part holds the partial remainder, low part dividend then quotient
    assign trial = in_acc[DW+NW-1:NW-1];
    assign diff  = trial - {1'b0, in_div};

    always_comb
    begin
        if (trial >= {1'b0, in_div})
            acc_next = {diff[DW-1:0], in_acc[NW-2:0], 1'b1};
        else
            acc_next = {in_acc[DW+NW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg <= acc_next;
            div_reg <= in_div;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== sv/fbpb_div_chain.sv =====
// ----------------------------------------------------------------------------
// fbpb_div_chain
// Row of division cells, one per quotient bit, with side data alongside.
// ----------------------------------------------------------------------------
module fbpb_div_chain #(
    parameter int NW = 22,
    parameter int DW = 16,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [NW-1:0] out_quot,
    output logic [PW-1:0] out_pay
);

    logic             v   [NW+1];
    logic [DW+NW-1:0] acc [NW+1];
    logic [DW-1:0]    dv  [NW+1];
    logic [PW-1:0]    pay [NW+1];

    assign v[0]   = in_valid;
    assign acc[0] = {{DW{1'b0}}, in_num};
    assign dv[0]  = in_div;
    assign pay[0] = in_pay;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        fbpb_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (v[i]),
            .in_acc    (acc[i]),
            .in_div    (dv[i]),
            .in_pay    (pay[i]),
            .out_valid (v[i+1]),
            .out_acc   (acc[i+1]),
            .out_div   (dv[i+1]),
            .out_pay   (pay[i+1])
        );
    end

    assign out_valid = v[NW];
    assign out_quot  = acc[NW][NW-1:0];
    assign out_pay   = pay[NW];

endmodule

// ===== sv/fat_boot_sector_bpb_decode.sv =====
// ----------------------------------------------------------------------------
// fat_boot_sector_bpb_decode
// Checks a FAT12/FAT16 boot sector record and derives the volume layout.
// ----------------------------------------------------------------------------
// usage
//   sector : valid/ready sink, one decoded boot sector record per request
//   result : valid/ready source, exactly one result per request, in order
//   cfg_we/cfg_index/cfg_data : register writes, only while the block is idle
// timing
//   from accept to result valid a record passes 22 cells of the root
//   directory divider (one quotient bit each), 32 cells of the cluster count
//   divider and the output register
//   a new request is taken every cycle unless result.ready stalls; the two
//   bit-serial divider rows are fully pipelined, one record per cycle
// stall and reset
//   while a result waits and result.ready is low the whole row of cells
//   holds and sector.ready drops; nothing is lost or repeated
//   reset empties the pipeline and loads the register defaults
// ----------------------------------------------------------------------------
module fat_boot_sector_bpb_decode (
    input  logic                                   clk,
    input  logic                                   rst_n,
    fbpb_sector_if.sink                            sector,
    fbpb_result_if.source                          result,
    input  logic                                   cfg_we,
    input  logic [fbpb_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fbpb_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int RPW = $bits(fbpb_pkg::root_pay_t);
    localparam int CPW = $bits(fbpb_pkg::cl_pay_t);

    logic [15:0] max_sector_reg;
    logic [16:0] max_cluster_reg;
    logic [7:0]  min_fats_reg;
    logic [7:0]  max_fats_reg;
    logic [15:0] fat12_limit_reg;
    logic [15:0] fat16_limit_reg;
    logic        single_support_reg;

    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sector_reg     <= 16'd4096;
            max_cluster_reg    <= 17'd32768;
            min_fats_reg       <= 8'd1;
            max_fats_reg       <= 8'd2;
            fat12_limit_reg    <= 16'd4084;
            fat16_limit_reg    <= 16'd65524;
            single_support_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fbpb_pkg::REG_MAX_SECTOR_BYTES:    max_sector_reg     <= cfg_data[15:0];
                fbpb_pkg::REG_MAX_CLUSTER_BYTES:   max_cluster_reg    <= cfg_data;
                fbpb_pkg::REG_MIN_FAT_COUNT:       min_fats_reg       <= cfg_data[7:0];
                fbpb_pkg::REG_MAX_FAT_COUNT:       max_fats_reg       <= cfg_data[7:0];
                fbpb_pkg::REG_FAT12_CLUSTER_LIMIT: fat12_limit_reg    <= cfg_data[15:0];
                fbpb_pkg::REG_FAT16_CLUSTER_LIMIT: fat16_limit_reg    <= cfg_data[15:0];
                fbpb_pkg::REG_SINGLE_FAT_SUPPORT:  single_support_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front checks ahead of the root directory divider
    fbpb_pkg::sector_t   s;
    fbpb_pkg::root_pay_t rpay;
    logic [23:0]         clb;
    logic [7:0]          fats;
    logic [15:0]         res1;
    logic [21:0]         root_num;

    assign s = sector.data;

    always_comb
    begin
        clb  = 24'(s.bytes_per_sector) * 24'(s.sectors_per_cluster);
        fats = (s.fat_copies == 8'd0) ? 8'd2 : s.fat_copies;
        res1 = (s.reserved_sectors == 16'd0) ? 16'd1 : s.reserved_sectors;

        if (s.bytes_per_sector > max_sector_reg)
            rpay.status = fbpb_pkg::ST_SECTOR_SIZE;
        else if (clb == 24'd0 || clb > {7'd0, max_cluster_reg})
            rpay.status = fbpb_pkg::ST_BAD_CLUSTER;
        else if (fats < min_fats_reg || fats > max_fats_reg)
            rpay.status = fbpb_pkg::ST_BAD_FATS;
        else
            rpay.status = fbpb_pkg::ST_OK;

        rpay.clbytes = clb[16:0];
        if (!single_support_reg || fats >= 8'd2)
            rpay.fatrec = {1'b0, res1} + {1'b0, s.sectors_per_fat};
        else
            rpay.fatrec = {1'b0, res1};
        rpay.fsiz    = s.sectors_per_fat;
        if (s.total_sectors_short != 16'd0)
            rpay.total = {16'd0, s.total_sectors_short};
        else if (s.is_floppy)
            rpay.total = 32'd0;
        else
            rpay.total = s.total_sectors_long;
        rpay.spc     = s.sectors_per_cluster;
        rpay.one_fat = single_support_reg && (fats < 8'd2);

        // rounded-up division of the root directory bytes
        root_num = {1'b0, s.root_entries, 5'd0} + {6'd0, s.bytes_per_sector} - 22'd1;
    end

    logic                r_valid;
    logic [21:0]         r_quot;
    logic [RPW-1:0]      r_pay_bits;
    fbpb_pkg::root_pay_t r_pay;

    fbpb_div_chain #(.NW(fbpb_pkg::ROOT_NUM_W), .DW(fbpb_pkg::ROOT_DIV_W), .PW(RPW)) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sector.valid),
        .in_num    (root_num),
        .in_div    (s.bytes_per_sector),
        .in_pay    (rpay),
        .out_valid (r_valid),
        .out_quot  (r_quot),
        .out_pay   (r_pay_bits)
    );

    assign r_pay = fbpb_pkg::root_pay_t'(r_pay_bits);

    // layout between the two dividers
    fbpb_pkg::cl_pay_t cpay;
    logic [31:0]       cl_num;

    always_comb
    begin
        cpay.status    = r_pay.status;
        cpay.clbytes   = r_pay.clbytes;
        cpay.rdlen     = r_quot[20:0];
        cpay.fatrec    = r_pay.fatrec;
        cpay.datrec    = {5'd0, r_pay.fatrec} + {6'd0, r_pay.fsiz} + r_quot;
        cpay.fsiz_zero = (r_pay.fsiz == 16'd0);
        cpay.one_fat   = r_pay.one_fat;
        if (r_pay.total < {10'd0, cpay.datrec})
            cl_num = 32'd0;
        else
            cl_num = r_pay.total - {10'd0, cpay.datrec};
    end

    logic              c_valid;
    logic [31:0]       c_quot;
    logic [CPW-1:0]    c_pay_bits;
    fbpb_pkg::cl_pay_t c_pay;

    fbpb_div_chain #(.NW(fbpb_pkg::CL_NUM_W), .DW(fbpb_pkg::CL_DIV_W), .PW(CPW)) u_clus (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (r_valid),
        .in_num    (cl_num),
        .in_div    (r_pay.spc),
        .in_pay    (cpay),
        .out_valid (c_valid),
        .out_quot  (c_quot),
        .out_pay   (c_pay_bits)
    );

    assign c_pay = fbpb_pkg::cl_pay_t'(c_pay_bits);

    // final status and output register
    fbpb_pkg::result_t res_next;
    fbpb_pkg::result_t res_reg;
    logic              res_valid_reg;

    always_comb
    begin
        res_next = '0;
        if (c_pay.status != fbpb_pkg::ST_OK)
            res_next.status = c_pay.status;
        else if (c_quot > {16'd0, fat16_limit_reg} || c_pay.fsiz_zero)
            res_next.status = fbpb_pkg::ST_FAT32;
        else
        begin
            res_next.status            = fbpb_pkg::ST_OK;
            res_next.cluster_bytes     = c_pay.clbytes;
            res_next.root_dir_sectors  = c_pay.rdlen;
            res_next.fat_start_sector  = c_pay.fatrec;
            res_next.data_start_sector = c_pay.datrec;
            res_next.cluster_count     = c_quot[15:0];
            res_next.is_fat16          = (c_quot > {16'd0, fat12_limit_reg});
            res_next.single_fat        = c_pay.one_fat;
        end
    end

    assign adv = !res_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= c_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign sector.ready = adv;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // a rejected record carries no layout
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.status != fbpb_pkg::ST_OK |->
            result.data.cluster_bytes == 17'd0 && result.data.cluster_count == 16'd0 &&
            result.data.data_start_sector == 22'd0)
        else $error("rejected result carries layout data");

    a_ok_cluster: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.status == fbpb_pkg::ST_OK |->
            result.data.cluster_bytes != 17'd0 &&
            result.data.cluster_count <= fat16_limit_reg)
        else $error("accepted result violates cluster bounds");

    a_fat16_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.is_fat16 |->
            result.data.cluster_count > fat12_limit_reg)
        else $error("fat16 flag without cluster count above limit");

endmodule
